[rtl/core/cft_pkg.sv]
package cft_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE     = 1'd1;

    // register reset values
    localparam logic [7:0] SEPARATOR_RST = 8'd44;
    localparam logic [7:0] QUOTE_RST     = 8'd34;

    // fixed byte codes
    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] LF_BYTE = 8'h0A;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    // default column limit
    localparam int MAX_COLUMNS_DEF = 256;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one queue entry: up to two results caused by one input byte
    // a: data byte, separator/newline marker or bare end marker
    // b: closing marker of a non-empty field at stream end (row end, stream end)
    typedef struct packed {
        logic       has_a;
        logic       a_kind;
        logic [7:0] a_data;
        logic       a_row;
        logic       a_send;
        logic       has_b;
        logic [7:0] col;
    } t_entry;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/core/cft_front.sv]
module cft_front #(
    parameter int P_MAX_COLUMNS = cft_pkg::MAX_COLUMNS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic [7:0]        i_sep,
    input  logic [7:0]        i_quote,
    input  cft_pkg::t_q_status i_q_status,
    output logic              o_push,
    output cft_pkg::t_entry   o_entry
);

    localparam int LIM_RAW = (P_MAX_COLUMNS > 1) ? (P_MAX_COLUMNS - 1) : 0;
    localparam logic [7:0] COL_LIMIT = (LIM_RAW > 255) ? 8'd255 : 8'(LIM_RAW);

    logic       r_in_quotes;
    logic       r_quote_pending;
    logic       r_field_nonempty;
    logic [7:0] r_column;
    logic       n_in_quotes;
    logic       n_quote_pending;
    logic       n_field_nonempty;
    logic [7:0] n_column;

    logic            is_sep;
    logic            is_quote;
    logic            inq;
    logic            accept;
    cft_pkg::t_entry ent;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    // classify the byte and work out the results and next state
    always_comb begin
        is_sep           = (i_byte == i_sep);
        is_quote         = (i_byte == i_quote) && !is_sep;
        inq              = r_in_quotes;
        n_in_quotes      = r_in_quotes;
        n_quote_pending  = 1'b0;
        n_field_nonempty = r_field_nonempty;
        n_column         = r_column;
        ent              = '0;
        ent.col          = r_column;

        if (r_quote_pending && is_quote) begin
            // doubled quote inside quotes gives one literal quote
            ent.has_a        = 1'b1;
            ent.a_kind       = cft_pkg::KIND_DATA;
            ent.a_data       = i_byte;
            n_field_nonempty = 1'b1;
        end else begin
            if (r_quote_pending) begin
                inq = 1'b0;
            end
            n_in_quotes = inq;
            if (is_sep) begin
                ent.has_a = 1'b1;
                if (inq) begin
                    ent.a_kind       = cft_pkg::KIND_DATA;
                    ent.a_data       = i_byte;
                    n_field_nonempty = 1'b1;
                end else begin
                    ent.a_kind       = cft_pkg::KIND_MARKER;
                    n_field_nonempty = 1'b0;
                    if (r_column < COL_LIMIT) begin
                        n_column = r_column + 8'd1;
                    end
                end
            end else if (is_quote) begin
                if (inq) begin
                    if (i_last) begin
                        n_in_quotes = 1'b0;
                    end else begin
                        n_quote_pending = 1'b1;
                    end
                end else begin
                    n_in_quotes = 1'b1;
                end
            end else if (i_byte == cft_pkg::CR_BYTE) begin
                // carriage return dropped
            end else if (i_byte == cft_pkg::LF_BYTE) begin
                ent.has_a = 1'b1;
                if (inq) begin
                    ent.a_kind       = cft_pkg::KIND_DATA;
                    ent.a_data       = i_byte;
                    n_field_nonempty = 1'b1;
                end else begin
                    ent.a_kind       = cft_pkg::KIND_MARKER;
                    ent.a_row        = 1'b1;
                    n_field_nonempty = 1'b0;
                    n_column         = 8'd0;
                end
            end else begin
                ent.has_a        = 1'b1;
                ent.a_kind       = cft_pkg::KIND_DATA;
                ent.a_data       = i_byte;
                n_field_nonempty = 1'b1;
            end
        end

        // stream end closes the open field, flags the last marker or adds a bare end marker
        if (i_last) begin
            if (n_field_nonempty) begin
                ent.has_b = 1'b1;
            end else if (ent.has_a) begin
                ent.a_send = 1'b1;
            end else begin
                ent.has_a  = 1'b1;
                ent.a_kind = cft_pkg::KIND_MARKER;
                ent.a_send = 1'b1;
            end
            n_in_quotes      = 1'b0;
            n_quote_pending  = 1'b0;
            n_field_nonempty = 1'b0;
            n_column         = 8'd0;
        end
    end

    assign o_push  = accept && (ent.has_a || ent.has_b);
    assign o_entry = ent;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes      <= 1'b0;
            r_quote_pending  <= 1'b0;
            r_field_nonempty <= 1'b0;
            r_column         <= 8'd0;
        end else if (accept) begin
            r_in_quotes      <= n_in_quotes;
            r_quote_pending  <= n_quote_pending;
            r_field_nonempty <= n_field_nonempty;
            r_column         <= n_column;
        end
    end

endmodule

[rtl/core/cft_queue.sv]
module cft_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cft_pkg::t_entry    i_entry,
    input  logic               i_pop,
    output cft_pkg::t_entry    o_head,
    output cft_pkg::t_q_status o_status
);

    cft_pkg::t_entry                r_mem [cft_pkg::QUEUE_DEPTH];
    logic [cft_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [cft_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [cft_pkg::QCNT_W-1:0]     r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_status.full  = (r_count == cft_pkg::QCNT_W'(cft_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/cft_back.sv]
module cft_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cft_pkg::t_entry    i_head,
    input  cft_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_kind,
    output logic [7:0]         o_data,
    output logic [7:0]         o_col,
    output logic               o_row_end,
    output logic               o_stream_end,
    output logic               o_last
);

    logic       r_phase;
    logic       r_valid;
    logic       r_kind;
    logic [7:0] r_data;
    logic [7:0] r_col;
    logic       r_row;
    logic       r_send;
    logic       r_last;
    logic       n_phase;
    logic       n_kind;
    logic [7:0] n_data;
    logic       n_row;
    logic       n_send;
    logic       n_last;
    logic       load;
    logic       take;

    assign load = !r_valid || i_ready;
    assign take = load && !i_q_status.empty;

    // pick the next result out of the head entry
    always_comb begin
        n_phase = r_phase;
        n_kind  = cft_pkg::KIND_MARKER;
        n_data  = 8'd0;
        n_row   = 1'b1;
        n_send  = 1'b1;
        n_last  = 1'b1;
        o_pop   = 1'b0;
        if (!r_phase && i_head.has_a) begin
            n_kind = i_head.a_kind;
            n_data = i_head.a_data;
            n_row  = i_head.a_row;
            n_send = i_head.a_send;
            n_last = !i_head.has_b;
            if (take) begin
                if (i_head.has_b) begin
                    n_phase = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end
        end else if (take) begin
            // closing marker of the open field
            n_phase = 1'b0;
            o_pop   = 1'b1;
        end
    end

    // output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_status.empty;
            r_phase <= n_phase;
        end
    end

    // output stage payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind <= n_kind;
            r_data <= n_data;
            r_col  <= i_head.col;
            r_row  <= n_row;
            r_send <= n_send;
            r_last <= n_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_data       = r_data;
    assign o_col        = r_col;
    assign o_row_end    = r_row;
    assign o_stream_end = r_send;
    assign o_last       = r_last;

endmodule

[rtl/core/csv_field_tokenizer_top.sv]
// channel      | direction | beat contents
// s_axis       | in        | tdata[7:0] in_byte, tlast in_last
// m_axis       | out       | tuser result_kind, tdata data/column/row_end/stream_end,
//              |           | tlast last_of_run
// cfg          | in        | index 0 separator_char, 1 quote_char, 8-bit data
//
// one input byte per cycle; each byte is classified combinationally by the front,
// its results wait in a 4-entry queue and leave one per cycle from the back's
// output register, so a byte that causes two results leaves as two output
// beats. synchronous active-low reset clears parser state, the queue and
// the output stage; configuration registers return to comma and double quote.
// either side may stall on its own; the input stalls only when the queue fills.
module csv_field_tokenizer_top #(
    parameter int P_MAX_COLUMNS = cft_pkg::MAX_COLUMNS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input byte stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // [7:0] in_byte
    input  logic                          i_s_axis_tlast,
    // result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [7:0] data_byte, [15:8] column_index, [16] row_end, [17] stream_end, [23:18] zero
    output logic [23:0]                   o_m_axis_tdata,
    output logic                          o_m_axis_tuser,  // [0] result_kind
    output logic                          o_m_axis_tlast,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cft_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    logic [7:0]         r_sep;
    logic [7:0]         r_quote;
    logic               push;
    logic               pop;
    cft_pkg::t_entry    push_entry;
    cft_pkg::t_entry    head;
    cft_pkg::t_q_status q_status;
    logic               kind;
    logic [7:0]         data_byte;
    logic [7:0]         col;
    logic               row_end;
    logic               stream_end;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep   <= cft_pkg::SEPARATOR_RST;
            r_quote <= cft_pkg::QUOTE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cft_pkg::CFG_SEPARATOR: r_sep   <= i_cfg_data;
                cft_pkg::CFG_QUOTE:     r_quote <= i_cfg_data;
                default:                r_sep   <= r_sep;
            endcase
        end
    end

    cft_front #(
        .P_MAX_COLUMNS (P_MAX_COLUMNS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_byte     (i_s_axis_tdata),
        .i_last     (i_s_axis_tlast),
        .i_sep      (r_sep),
        .i_quote    (r_quote),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    cft_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    cft_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_kind       (kind),
        .o_data       (data_byte),
        .o_col        (col),
        .o_row_end    (row_end),
        .o_stream_end (stream_end),
        .o_last       (o_m_axis_tlast)
    );

    // pack the result beat
    assign o_m_axis_tdata = {6'd0, stream_end, row_end, col, data_byte};
    assign o_m_axis_tuser = kind;

endmodule

[rtl/core/cft_checker.sv]
module cft_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // a stalled result beat stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("result payload changed while stalled");

    // stream end only on the closing marker of a byte's results
    a_send_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[17] |-> o_m_axis_tuser && o_m_axis_tlast)
        else $error("stream end on a non-final or data beat");

    // data beats never carry row or stream end
    a_data_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[17:16] == 2'b00)
        else $error("data beat carries marker flags");

    // stream end resets the column for the next stream
    a_col_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tdata[17] ##1
            o_m_axis_tvalid && o_m_axis_tuser && !o_m_axis_tdata[16]
            |-> o_m_axis_tdata[15:8] == 8'd0)
        else $error("column not restarted after stream end");

endmodule

bind csv_field_tokenizer_top cft_checker u_cft_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

[tb/csv_tok_checker.sv]
`timescale 1ns / 100ps

module csv_tok_checker
    import cft_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input byte channel
    input  logic                 i_s_valid,
    input  logic                 i_s_ready,
    input  logic [7:0]           i_s_data,
    input  logic                 i_s_last,
    // result channel
    input  logic                 i_m_valid,
    input  logic                 i_m_ready,
    input  logic [23:0]          i_m_data,
    input  logic                 i_m_user,
    input  logic                 i_m_last,
    // configuration channel
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [7:0] col;
        logic       row;
        logic       send;
        logic       last;
    } t_tok;

    localparam int COL_LIM_RAW = (MAX_COLUMNS > 1) ? MAX_COLUMNS - 1 : 0;
    localparam logic [7:0] COL_LIMIT = (COL_LIM_RAW > 255) ? 8'd255 : 8'(COL_LIM_RAW);

    // register copies and parser state
    logic [7:0] sep_reg;
    logic [7:0] quote_reg;
    logic       in_quotes;
    logic       quote_pend;
    logic       field_open;
    logic [7:0] col_count;

    t_tok token_q[$];
    int   mismatch_count;

    assign o_fail_count = mismatch_count;

    initial begin
        mismatch_count = 0;
        o_pending      = 0;
    end

    function automatic t_tok make_tok(logic kind, logic [7:0] data, logic row, logic send);
        t_tok t;
        t.kind = kind;
        t.data = data;
        t.col  = col_count;
        t.row  = row;
        t.send = send;
        t.last = 1'b0;
        return t;
    endfunction

    // expected tokens for one input byte
    task automatic tokenize_byte(input logic [7:0] b, input logic fin);
        t_tok res[$];
        logic is_sep;
        logic is_q;
        logic done;
        done   = 1'b0;
        is_sep = (b == sep_reg);
        is_q   = (b == quote_reg) && !is_sep;

        // resolve a quote held from the previous byte
        if (quote_pend) begin
            quote_pend = 1'b0;
            if (is_q) begin
                res.push_back(make_tok(KIND_DATA, b, 1'b0, 1'b0));
                field_open = 1'b1;
                done = 1'b1;
            end else begin
                in_quotes = 1'b0;
            end
        end

        if (!done) begin
            if (is_sep) begin
                if (in_quotes) begin
                    res.push_back(make_tok(KIND_DATA, b, 1'b0, 1'b0));
                    field_open = 1'b1;
                end else begin
                    res.push_back(make_tok(KIND_MARKER, 8'd0, 1'b0, 1'b0));
                    field_open = 1'b0;
                    if (col_count < COL_LIMIT) col_count = col_count + 8'd1;
                end
            end else if (is_q) begin
                if (in_quotes) begin
                    if (fin) in_quotes = 1'b0;
                    else quote_pend = 1'b1;
                end else begin
                    in_quotes = 1'b1;
                end
            end else if (b != CR_BYTE) begin
                // carriage returns fall through and are dropped
                if (b == LF_BYTE && !in_quotes) begin
                    res.push_back(make_tok(KIND_MARKER, 8'd0, 1'b1, 1'b0));
                    field_open = 1'b0;
                    col_count = 8'd0;
                end else begin
                    res.push_back(make_tok(KIND_DATA, b, 1'b0, 1'b0));
                    field_open = 1'b1;
                end
            end
        end

        // close the stream on the final byte
        if (fin) begin
            if (field_open) res.push_back(make_tok(KIND_MARKER, 8'd0, 1'b1, 1'b1));
            else if (res.size() > 0) res[res.size()-1].send = 1'b1;
            else res.push_back(make_tok(KIND_MARKER, 8'd0, 1'b0, 1'b1));
            in_quotes  = 1'b0;
            quote_pend = 1'b0;
            field_open = 1'b0;
            col_count  = 8'd0;
        end

        if (res.size() > 0) res[res.size()-1].last = 1'b1;
        foreach (res[i]) token_q.push_back(res[i]);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // watch all channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_tok want;
        if (!i_rst_n) begin
            sep_reg    = SEPARATOR_RST;
            quote_reg  = QUOTE_RST;
            in_quotes  = 1'b0;
            quote_pend = 1'b0;
            field_open = 1'b0;
            col_count  = 8'd0;
            token_q.delete();
        end else begin
            // register write beat
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SEPARATOR: sep_reg = i_cfg_data;
                    CFG_QUOTE:     quote_reg = i_cfg_data;
                    default: ;
                endcase
            end
            // input beat
            if (i_s_valid && i_s_ready) tokenize_byte(i_s_data, i_s_last);
            // result beat
            if (i_m_valid && i_m_ready) begin
                if (token_q.size() == 0) begin
                    $error("unexpected result beat: tdata %0h tuser %0b tlast %0b",
                           i_m_data, i_m_user, i_m_last);
                    mismatch_count++;
                end else begin
                    want = token_q.pop_front();
                    check_field("result_kind", {7'd0, want.kind}, {7'd0, i_m_user});
                    check_field("data_byte", want.data, i_m_data[7:0]);
                    check_field("column_index", want.col, i_m_data[15:8]);
                    check_field("row_end", {7'd0, want.row}, {7'd0, i_m_data[16]});
                    check_field("stream_end", {7'd0, want.send}, {7'd0, i_m_data[17]});
                    check_field("tdata_pad", 8'd0, {2'd0, i_m_data[23:18]});
                    check_field("last_of_run", {7'd0, want.last}, {7'd0, i_m_last});
                end
            end
        end
        // results still owed by the block
        o_pending = token_q.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import cft_pkg::*;

    localparam int COLUMNS_PARAM  = MAX_COLUMNS_DEF;
    localparam int TOTAL_ITEMS    = 950;
    localparam int PHASE_ITEMS    = 90;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_data;
    logic                 s_last;
    logic                 m_valid;
    logic                 m_ready;
    logic [23:0]          m_data;
    logic                 m_user;
    logic                 m_last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    int   fail_count;
    int   pending;
    int   sent_count;
    int   idle_cycles;
    int   ready_hold;
    bit   no_idle;
    logic [7:0] cur_sep;
    logic [7:0] cur_quote;
    logic [7:0] rec_q[$];

    csv_field_tokenizer_top #(
        .P_MAX_COLUMNS(COLUMNS_PARAM)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tlast (s_last),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user),
        .o_m_axis_tlast (m_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    csv_tok_checker #(
        .MAX_COLUMNS(COLUMNS_PARAM)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_valid),
        .i_s_ready   (s_ready),
        .i_s_data    (s_data),
        .i_s_last    (s_last),
        .i_m_valid   (m_valid),
        .i_m_ready   (m_ready),
        .i_m_data    (m_data),
        .i_m_user    (m_user),
        .i_m_last    (m_last),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // gap length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        else if (r < 95) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    // random back-pressure on the result channel
    always @(negedge i_clk) begin
        if (no_idle) begin
            m_ready <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else if (m_ready) begin
            m_ready <= 1'b0;
            ready_hold = idle_len() - 1;
        end else begin
            m_ready <= 1'b1;
            ready_hold = $urandom_range(0, 15);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one input beat; entered and left just after a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = (no_idle || $urandom_range(0, 1)) ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= fin;
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
        sent_count++;
    endtask

    // wait until every expected result is out and the block has settled
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SEPARATOR) cur_sep = val;
        else cur_quote = val;
    endtask

    task automatic set_config(input logic [7:0] sep, input logic [7:0] quo);
        wait_idle();
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_SEPARATOR, sep);
            write_reg(CFG_QUOTE, quo);
        end else begin
            write_reg(CFG_QUOTE, quo);
            write_reg(CFG_SEPARATOR, sep);
        end
        @(negedge i_clk);
    endtask

    // field content: mostly letters, sometimes any byte
    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h61, 8'h7a));
    endfunction

    // build one csv record into rec_q
    task automatic build_record(input bit wide);
        int n_fields;
        int kind;
        int len;
        int r;
        rec_q.delete();
        n_fields = wide ? $urandom_range(256, 270) : $urandom_range(1, 6);
        for (int f = 0; f < n_fields; f++) begin
            if (f > 0) rec_q.push_back(cur_sep);
            kind = wide ? $urandom_range(0, 1) : $urandom_range(0, 3);
            if (kind == 3) begin
                // quoted field with embedded specials
                rec_q.push_back(cur_quote);
                len = $urandom_range(0, 5);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 9);
                    if (r < 5) rec_q.push_back(text_byte());
                    else if (r == 5) rec_q.push_back(cur_sep);
                    else if (r == 6) rec_q.push_back(LF_BYTE);
                    else if (r == 7) rec_q.push_back(CR_BYTE);
                    else begin
                        rec_q.push_back(cur_quote);
                        rec_q.push_back(cur_quote);
                    end
                end
                rec_q.push_back(cur_quote);
            end else if (kind != 0) begin
                len = wide ? 1 : $urandom_range(1, 5);
                for (int i = 0; i < len; i++) rec_q.push_back(text_byte());
            end
        end
        r = $urandom_range(0, 9);
        if (r < 6) rec_q.push_back(LF_BYTE);
        else if (r < 9) begin
            rec_q.push_back(CR_BYTE);
            rec_q.push_back(LF_BYTE);
        end
        if (rec_q.size() == 0) rec_q.push_back(LF_BYTE);
    endtask

    // random traffic for one configuration
    task automatic run_phase(input bit with_wide);
        int target;
        int r;
        int cut;
        bit fin_rec;
        if (with_wide) begin
            build_record(1'b1);
            foreach (rec_q[i]) send_byte(rec_q[i], 1'b0);
        end
        target = sent_count + PHASE_ITEMS;
        if (target > TOTAL_ITEMS) target = TOTAL_ITEMS;
        while (sent_count < target) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                // noise byte
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
            end else begin
                build_record(1'b0);
                fin_rec = ($urandom_range(0, 7) == 0);
                // broken record: cut off part way
                cut = (r < 22) ? $urandom_range(1, rec_q.size()) : rec_q.size();
                for (int i = 0; i < cut; i++) send_byte(rec_q[i], fin_rec && (i == cut - 1));
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        int phase;
        i_rst_n    = 1'b0;
        s_valid    = 1'b0;
        s_data     = 8'd0;
        s_last     = 1'b0;
        m_ready    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_SEPARATOR;
        cfg_data   = 8'd0;
        no_idle    = 1'b0;
        ready_hold = 0;
        idle_cycles = 0;
        sent_count = 0;
        cur_sep    = SEPARATOR_RST;
        cur_quote  = QUOTE_RST;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // plain fields, quoted separator, doubled quote, quoted newline
        send_byte("a", 1'b0);
        send_byte(",", 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(",", 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(LF_BYTE, 1'b0);
        // quote followed by other byte leaves quoted mode
        send_byte(8'h22, 1'b0);
        send_byte("b", 1'b0);
        send_byte(CR_BYTE, 1'b0);
        send_byte(LF_BYTE, 1'b0);
        // byte extremes, then closing quote on the final byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h22, 1'b1);
        // empty stream ending on a dropped byte
        send_byte(CR_BYTE, 1'b1);
        // trailing separator on the final byte
        send_byte(",", 1'b1);
        // pending quote resolved by a final newline
        send_byte(8'h22, 1'b0);
        send_byte("q", 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(LF_BYTE, 1'b1);

        // separator set to carriage return wins over dropping
        set_config(CR_BYTE, 8'h22);
        send_byte("x", 1'b0);
        send_byte(CR_BYTE, 1'b0);
        send_byte(LF_BYTE, 1'b0);
        // separator equal to quote disables quoting
        set_config(8'h27, 8'h27);
        send_byte(8'h27, 1'b0);
        send_byte("z", 1'b0);
        send_byte(8'h27, 1'b1);

        // random phases over several settings
        phase = 0;
        while (sent_count < TOTAL_ITEMS) begin
            case (phase % 6)
                0: set_config(SEPARATOR_RST, QUOTE_RST);
                1: set_config(8'h00, 8'hFF);
                2: set_config(8'hFF, 8'h00);
                3: begin
                    cur_sep = 8'($urandom_range(0, 255));
                    set_config(cur_sep, cur_sep);
                end
                4: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: set_config(LF_BYTE, 8'h27);
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            run_phase(phase == 0);
            phase++;
        end

        // drain
        no_idle = 1'b0;
        wait_idle();
        repeat (2 * DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/cft_pkg.sv
rtl/core/cft_front.sv
rtl/core/cft_queue.sv
rtl/core/cft_back.sv
rtl/core/csv_field_tokenizer_top.sv
rtl/core/cft_checker.sv
tb/csv_tok_checker.sv
tb/tb_top.sv
